// ----- hw/rtl/ctm_pkg.sv -----
// ctm_pkg: shared types, constants and calendar helper functions for cron_time_match
// no dependencies; imported by every module of the block

package ctm_pkg;

    // field widths of the candidate time and the packed stamp
    localparam int YEAR_W    = 14;
    localparam int MONTH_W   = 4;
    localparam int DAY_W     = 5;
    localparam int HOUR_W    = 5;
    localparam int MINUTE_W  = 6;
    localparam int WEEKDAY_W = 3;
    localparam int STAMP_W   = 40;

    // configuration register widths
    localparam int MINUTE_MASK_W  = 60;
    localparam int HOUR_MASK_W    = 24;
    localparam int DAY_MASK_W     = 31;
    localparam int MONTH_MASK_W   = 12;
    localparam int WEEKDAY_MASK_W = 7;

    // apb port geometry: 64-bit registers at 8-byte spacing
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 6;
    localparam int REG_LSB    = 3;

    // stamp digit weights, yyyymmddHHMM
    localparam logic [STAMP_W-1:0] STAMP_YEAR_SCALE = 40'd100000000;
    localparam logic [23:0]        STAMP_MONTH_SCALE = 24'd1000000;
    localparam logic [18:0]        STAMP_DAY_SCALE   = 19'd10000;
    localparam logic [11:0]        STAMP_HOUR_SCALE  = 12'd100;

    // gregorian year limits
    localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;
    localparam logic [YEAR_W-1:0] CENTURY  = 14'd100;

    // reciprocal of 100: (y * 5243) >> 19 is exact for y below 2^14
    localparam logic [12:0] RECIP_100       = 13'd5243;
    localparam int          RECIP_100_SHIFT = 19;

    // reciprocal of 7: (w * 293) >> 11 is exact for w below 2^9
    localparam logic [8:0] RECIP_7       = 9'd293;
    localparam int         RECIP_7_SHIFT = 11;
    localparam logic [8:0] DAYS_PER_WEEK = 9'd7;

    // multiple of 7 that keeps the zeller sum non-negative
    localparam logic [8:0] ZELLER_BIAS = 9'd210;

    localparam logic [DAY_W-1:0] FEB_DAYS      = 5'd28;
    localparam logic [DAY_W-1:0] FEB_LEAP_DAYS = 5'd29;
    localparam logic [DAY_W-1:0] SHORT_MONTH   = 5'd30;
    localparam logic [DAY_W-1:0] LONG_MONTH    = 5'd31;

    // register map index
    typedef enum logic [2:0] {
        REG_MINUTE_MASK,
        REG_HOUR_MASK,
        REG_DAY_MASK,
        REG_MONTH_MASK,
        REG_WEEKDAY_MASK,
        REG_WIN_START,
        REG_WIN_END
    } t_reg_idx;

    // programmed rule
    typedef struct packed {
        logic [MINUTE_MASK_W-1:0]  minute_mask;
        logic [HOUR_MASK_W-1:0]    hour_mask;
        logic [DAY_MASK_W-1:0]     day_mask;
        logic [MONTH_MASK_W-1:0]   month_mask;
        logic [WEEKDAY_MASK_W-1:0] weekday_mask;
        logic [STAMP_W-1:0]        win_start;
        logic [STAMP_W-1:0]        win_end;
    } t_cfg;

    // per-stage load enables of the pipeline
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_pipe_en;

    // days in a month, zero for a month code that names no month
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        case (m) inside
            4'd2:                              len = leap ? FEB_LEAP_DAYS : FEB_DAYS;
            4'd4, 4'd6, 4'd9, 4'd11:           len = SHORT_MONTH;
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8,
            4'd10, 4'd12:                      len = LONG_MONTH;
            default:                           len = '0;
        endcase
        return len;
    endfunction

    // zeller month term 26*(m+1)/10, january and february counted as 13 and 14
    function automatic logic [5:0] zeller_month_term(input logic [MONTH_W-1:0] m);
        logic [5:0] t;
        case (m)
            4'd1:    t = 6'd36;
            4'd2:    t = 6'd39;
            4'd3:    t = 6'd10;
            4'd4:    t = 6'd13;
            4'd5:    t = 6'd15;
            4'd6:    t = 6'd18;
            4'd7:    t = 6'd20;
            4'd8:    t = 6'd23;
            4'd9:    t = 6'd26;
            4'd10:   t = 6'd28;
            4'd11:   t = 6'd31;
            4'd12:   t = 6'd33;
            default: t = '0;
        endcase
        return t;
    endfunction

endpackage

// ----- hw/rtl/cron_time_match.sv -----
// cron_time_match checks one candidate minute (year, month, day, hour, minute) per word
// against a cron rule programmed over the APB port: five field masks and a stamp window
// [window_start, window_end) in packed decimal yyyymmddHHMM. It reports date validity,
// the weekday (Sunday 0, forced to 0 for an invalid date), the stamp, the window test and
// fire. A word is accepted every cycle while o_ready is high; its result passes in order
// through the four register stages: input register (loaded at acceptance), multiply
// stage, sum stage, result register. A stalled output holds its word and empty stages still
// fill, so o_ready drops only when all four stages are full. No memories, no clearing pass
// after reset. Registers read back at byte address 8*index; write them only while no word
// is in flight.

module cron_time_match
    import ctm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // candidate minute
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [YEAR_W-1:0]     i_year,
    input  logic [MONTH_W-1:0]    i_month,
    input  logic [DAY_W-1:0]      i_day,
    input  logic [HOUR_W-1:0]     i_hour,
    input  logic [MINUTE_W-1:0]   i_minute,
    // result
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_fire,
    output logic                  o_date_valid,
    output logic                  o_in_window,
    output logic [WEEKDAY_W-1:0]  o_weekday,
    output logic [STAMP_W-1:0]    o_stamp,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg                cfg;
    t_pipe_en            en;
    logic                r_v1, r_v2, r_v3, r_v4;

    logic [YEAR_W-1:0]   r_s1_year;
    logic [MONTH_W-1:0]  r_s1_month;
    logic [DAY_W-1:0]    r_s1_day;
    logic [HOUR_W-1:0]   r_s1_hour;
    logic [MINUTE_W-1:0] r_s1_minute;
    logic [MONTH_W-1:0]  r_s2_month, r_s3_month;
    logic [DAY_W-1:0]    r_s2_day, r_s3_day;
    logic [HOUR_W-1:0]   r_s2_hour, r_s3_hour;
    logic [MINUTE_W-1:0] r_s2_minute, r_s3_minute;

    logic                cal_valid;
    logic [WEEKDAY_W-1:0] cal_weekday;
    logic [STAMP_W-1:0]  stamp;
    logic                in_window;
    logic [63:0]         minute_bits;
    logic [31:0]         hour_bits;
    logic [31:0]         day_bits;
    logic [15:0]         month_bits;
    logic [7:0]          weekday_bits;
    logic [DAY_W-1:0]    day_idx;
    logic [MONTH_W-1:0]  month_idx;
    logic                mask_match;
    logic                n_fire;

    logic                r_out_fire;
    logic                r_out_date_valid;
    logic                r_out_in_window;
    logic [WEEKDAY_W-1:0] r_out_weekday;
    logic [STAMP_W-1:0]  r_out_stamp;

    ctm_cfg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // a stage loads when empty or when its word moves on
    assign en.s4   = !r_v4 || i_ready;
    assign en.s3   = !r_v3 || en.s4;
    assign en.s2   = !r_v2 || en.s3;
    assign en.s1   = !r_v1 || en.s2;
    assign o_ready = en.s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en.s1) r_v1 <= i_valid;
            if (en.s2) r_v2 <= r_v1;
            if (en.s3) r_v3 <= r_v2;
            if (en.s4) r_v4 <= r_v3;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (en.s1) begin
            r_s1_year   <= i_year;
            r_s1_month  <= i_month;
            r_s1_day    <= i_day;
            r_s1_hour   <= i_hour;
            r_s1_minute <= i_minute;
        end
    end

    // fields carried alongside for the mask test
    always_ff @(posedge i_clk) begin
        if (en.s2) begin
            r_s2_month  <= r_s1_month;
            r_s2_day    <= r_s1_day;
            r_s2_hour   <= r_s1_hour;
            r_s2_minute <= r_s1_minute;
        end
        if (en.s3) begin
            r_s3_month  <= r_s2_month;
            r_s3_day    <= r_s2_day;
            r_s3_hour   <= r_s2_hour;
            r_s3_minute <= r_s2_minute;
        end
    end

    ctm_calendar u_cal (
        .i_clk        (i_clk),
        .i_en         (en),
        .i_year       (r_s1_year),
        .i_month      (r_s1_month),
        .i_day        (r_s1_day),
        .o_date_valid (cal_valid),
        .o_weekday    (cal_weekday)
    );

    ctm_stamp u_stamp (
        .i_clk       (i_clk),
        .i_en        (en),
        .i_cfg       (cfg),
        .i_year      (r_s1_year),
        .i_month     (r_s1_month),
        .i_day       (r_s1_day),
        .i_hour      (r_s1_hour),
        .i_minute    (r_s1_minute),
        .o_stamp     (stamp),
        .o_in_window (in_window)
    );

    // mask lookup; out-of-range hours and minutes land on zero padding
    assign minute_bits  = 64'(cfg.minute_mask);
    assign hour_bits    = 32'(cfg.hour_mask);
    assign day_bits     = 32'(cfg.day_mask);
    assign month_bits   = 16'(cfg.month_mask);
    assign weekday_bits = 8'(cfg.weekday_mask);
    assign day_idx      = r_s3_day - 5'd1;
    assign month_idx    = r_s3_month - 4'd1;
    assign mask_match   = minute_bits[r_s3_minute] && hour_bits[r_s3_hour] &&
                          day_bits[day_idx] && month_bits[month_idx] &&
                          weekday_bits[cal_weekday];
    assign n_fire       = cal_valid && mask_match && in_window;

    // result register
    always_ff @(posedge i_clk) begin
        if (en.s4) begin
            r_out_fire       <= n_fire;
            r_out_date_valid <= cal_valid;
            r_out_in_window  <= in_window;
            r_out_weekday    <= cal_weekday;
            r_out_stamp      <= stamp;
        end
    end

    assign o_valid      = r_v4;
    assign o_fire       = r_out_fire;
    assign o_date_valid = r_out_date_valid;
    assign o_in_window  = r_out_in_window;
    assign o_weekday    = r_out_weekday;
    assign o_stamp      = r_out_stamp;

`ifndef SYNTHESIS
    // input stalls only with every stage occupied
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_v1 && r_v2 && r_v3 && r_v4))
        else $error("input stalled with an empty pipeline stage");

    // fire needs a valid date and the window
    a_fire_cond: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_fire) |-> (o_date_valid && o_in_window))
        else $error("fire without valid date or window hit");

    // invalid date gives weekday zero
    a_weekday_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_date_valid) |-> (o_weekday == '0))
        else $error("weekday not zero on invalid date");

    // weekday stays below seven
    a_weekday_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_weekday != 3'd7))
        else $error("weekday out of range");
`endif

endmodule

// ----- hw/rtl/ctm_cfg_regs.sv -----
// ctm_cfg_regs: apb register file holding the cron rule masks and the stamp window
// depends on ctm_pkg

module ctm_cfg_regs
    import ctm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[APB_ADDR_W-1:REG_LSB]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    // register writes, each value cut to its register width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_MINUTE_MASK:  r_cfg.minute_mask  <= pwdata[MINUTE_MASK_W-1:0];
                REG_HOUR_MASK:    r_cfg.hour_mask    <= pwdata[HOUR_MASK_W-1:0];
                REG_DAY_MASK:     r_cfg.day_mask     <= pwdata[DAY_MASK_W-1:0];
                REG_MONTH_MASK:   r_cfg.month_mask   <= pwdata[MONTH_MASK_W-1:0];
                REG_WEEKDAY_MASK: r_cfg.weekday_mask <= pwdata[WEEKDAY_MASK_W-1:0];
                REG_WIN_START:    r_cfg.win_start    <= pwdata[STAMP_W-1:0];
                REG_WIN_END:      r_cfg.win_end      <= pwdata[STAMP_W-1:0];
                default: ;
            endcase
        end
    end

    // read-back mux
    always_comb begin
        unique case (reg_idx)
            REG_MINUTE_MASK:  prdata = APB_DATA_W'(r_cfg.minute_mask);
            REG_HOUR_MASK:    prdata = APB_DATA_W'(r_cfg.hour_mask);
            REG_DAY_MASK:     prdata = APB_DATA_W'(r_cfg.day_mask);
            REG_MONTH_MASK:   prdata = APB_DATA_W'(r_cfg.month_mask);
            REG_WEEKDAY_MASK: prdata = APB_DATA_W'(r_cfg.weekday_mask);
            REG_WIN_START:    prdata = APB_DATA_W'(r_cfg.win_start);
            REG_WIN_END:      prdata = APB_DATA_W'(r_cfg.win_end);
            default:          prdata = '0;
        endcase
    end

endmodule

// ----- hw/rtl/ctm_calendar.sv -----
// ctm_calendar: date validity and zeller weekday over two pipeline stages
// depends on ctm_pkg; stage enables come from the top-level pipeline control

module ctm_calendar
    import ctm_pkg::*;
(
    input  logic                 i_clk,
    input  t_pipe_en             i_en,
    input  logic [YEAR_W-1:0]    i_year,
    input  logic [MONTH_W-1:0]   i_month,
    input  logic [DAY_W-1:0]     i_day,
    output logic                 o_date_valid,
    output logic [WEEKDAY_W-1:0] o_weekday
);

    // stage 1 -> 2: century quotients of the year and the zeller year
    logic [26:0]        cy_prod;
    logic [26:0]        cyy_prod;
    logic [YEAR_W-1:0]  yy;

    // stage 2 registers
    logic [YEAR_W-1:0]  r_s2_year;
    logic [MONTH_W-1:0] r_s2_month;
    logic [DAY_W-1:0]   r_s2_day;
    logic [7:0]         r_s2_cy;
    logic [YEAR_W-1:0]  r_s2_yy;
    logic [7:0]         r_s2_cyy;

    // stage 2 -> 3
    logic [YEAR_W-1:0]  hund_y;
    logic [YEAR_W-1:0]  hund_yy;
    logic [YEAR_W-1:0]  yy_rem;
    logic               leap;
    logic [DAY_W-1:0]   len;
    logic               valid;
    logic [8:0]         w_sum;

    // stage 3 registers and weekday reduction
    logic               r_s3_valid;
    logic [8:0]         r_s3_w;
    logic [17:0]        q_prod;
    logic [6:0]         w_quot;
    logic [8:0]         w_mod;

    // january and february count as months 13 and 14 of the year before
    assign yy       = i_year - YEAR_W'(i_month <= 4'd2);
    assign cy_prod  = 27'(i_year) * 27'(RECIP_100);
    assign cyy_prod = 27'(yy) * 27'(RECIP_100);

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_s2_year  <= i_year;
            r_s2_month <= i_month;
            r_s2_day   <= i_day;
            r_s2_cy    <= cy_prod[RECIP_100_SHIFT+7:RECIP_100_SHIFT];
            r_s2_yy    <= yy;
            r_s2_cyy   <= cyy_prod[RECIP_100_SHIFT+7:RECIP_100_SHIFT];
        end
    end

    // leap year: divisible by 4, centuries only when divisible by 400
    assign hund_y = YEAR_W'({6'd0, r_s2_cy} * CENTURY);
    assign leap   = (r_s2_year == hund_y) ? (r_s2_cy[1:0] == 2'd0)
                                          : (r_s2_year[1:0] == 2'd0);
    assign len    = month_len(r_s2_month, leap);
    assign valid  = (r_s2_year != '0) && (r_s2_year <= YEAR_MAX) &&
                    (r_s2_day != '0) && (r_s2_day <= len);

    // zeller sum mod 512; in range whenever the date is valid
    assign hund_yy = YEAR_W'({6'd0, r_s2_cyy} * CENTURY);
    assign yy_rem  = r_s2_yy - hund_yy;
    assign w_sum   = 9'(r_s2_cyy >> 2) - {r_s2_cyy, 1'b0}
                   + 9'(yy_rem[6:0]) + 9'(yy_rem[6:2])
                   + 9'(zeller_month_term(r_s2_month))
                   + 9'(r_s2_day) - 9'd1 + ZELLER_BIAS;

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_s3_valid <= valid;
            r_s3_w     <= w_sum;
        end
    end

    // mod 7 through the reciprocal
    assign q_prod  = 18'(r_s3_w) * 18'(RECIP_7);
    assign w_quot  = q_prod[RECIP_7_SHIFT+6:RECIP_7_SHIFT];
    assign w_mod   = r_s3_w - 9'({2'd0, w_quot} * DAYS_PER_WEEK);

    assign o_date_valid = r_s3_valid;
    assign o_weekday    = r_s3_valid ? w_mod[WEEKDAY_W-1:0] : '0;

endmodule

// ----- hw/rtl/ctm_stamp.sv -----
// ctm_stamp: packed decimal stamp yyyymmddHHMM and the half-open window test
// depends on ctm_pkg; stage enables come from the top-level pipeline control

module ctm_stamp
    import ctm_pkg::*;
(
    input  logic                i_clk,
    input  t_pipe_en            i_en,
    input  t_cfg                i_cfg,
    input  logic [YEAR_W-1:0]   i_year,
    input  logic [MONTH_W-1:0]  i_month,
    input  logic [DAY_W-1:0]    i_day,
    input  logic [HOUR_W-1:0]   i_hour,
    input  logic [MINUTE_W-1:0] i_minute,
    output logic [STAMP_W-1:0]  o_stamp,
    output logic                o_in_window
);

    logic [STAMP_W-1:0]  r_s2_py;
    logic [23:0]         r_s2_pm;
    logic [18:0]         r_s2_pd;
    logic [11:0]         r_s2_ph;
    logic [MINUTE_W-1:0] r_s2_min;
    logic [STAMP_W-1:0]  stamp_sum;
    logic [STAMP_W-1:0]  r_s3_stamp;

    // digit weights, one constant product per field
    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_s2_py  <= STAMP_W'(i_year) * STAMP_YEAR_SCALE;
            r_s2_pm  <= 24'(i_month) * STAMP_MONTH_SCALE;
            r_s2_pd  <= 19'(i_day) * STAMP_DAY_SCALE;
            r_s2_ph  <= 12'(i_hour) * STAMP_HOUR_SCALE;
            r_s2_min <= i_minute;
        end
    end

    // sum wraps at 2^40
    assign stamp_sum = r_s2_py + STAMP_W'(r_s2_pm) + STAMP_W'(r_s2_pd)
                     + STAMP_W'(r_s2_ph) + STAMP_W'(r_s2_min);

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_s3_stamp <= stamp_sum;
        end
    end

    // start inclusive, end exclusive
    assign o_stamp     = r_s3_stamp;
    assign o_in_window = (i_cfg.win_start <= r_s3_stamp) && (r_s3_stamp < i_cfg.win_end);

endmodule
